@@ hw/rtl/command_retry_tracker_top_assert.svh @@
// Assertion macros used by the tracker engine.
`ifndef COMMAND_RETRY_TRACKER_TOP_ASSERT_SVH
`define COMMAND_RETRY_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTH
`define CRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CRT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/crt_pkg.sv @@
package crt_pkg;

	typedef enum logic [1:0] {
		CMD_ISSUE  = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_CANCEL = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		EV_SEND   = 2'd0,
		EV_STATUS = 2'd1,
		EV_FULL   = 2'd2
	} evt_t;

	typedef enum logic [1:0] {
		CFG_RETRY_INTERVAL = 2'd0,
		CFG_MAX_ATTEMPTS   = 2'd1
	} cfg_reg_t;

	localparam logic [2:0] ST_SENDING   = 3'd1;
	localparam logic [2:0] ST_COMPLETED = 3'd3;
	localparam logic [2:0] ST_REJECTED  = 3'd4;
	localparam logic [2:0] ST_CANCELED  = 3'd5;

	localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd500;
	localparam logic [2:0]  MAX_ATTEMPTS_RESET   = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ALLOC,
		S_REPORT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] vehicle_id;
		logic [7:0] command_type;
		logic [2:0] ack_status;
	} req_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [3:0] entry_slot;
		logic [7:0] out_vehicle;
		logic [7:0] out_type;
		logic [2:0] attempt;
		logic [2:0] new_status;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  vehicle;
		logic [7:0]  ctype;
		logic [2:0]  attempts;
		logic [15:0] countdown;
	} entry_t;

endpackage

@@ hw/rtl/command_retry_tracker_top.sv @@
// Outstanding-command tracker: each request (issue, acknowledge, cancel or tick) walks the
// slot table one entry per cycle, except while the result side stalls or a slot rejected on
// a tick reports its rejection, through the read port and write port of the slot memory.
// Results of an acknowledge, cancel or tick leave in ascending slot order, with last set on
// the final result of a request; acknowledge, cancel and tick requests that touch no entry
// produce nothing. Valid bits clear at reset, so no clearing pass is needed.
// Configuration writes (index 0 retry interval, 1 max attempts) are always accepted; make
// them only while no request is in flight.
module command_retry_tracker_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  crt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output crt_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	logic [15:0]   retry_interval_q;
	logic [2:0]    max_attempts_q;
	logic          push_valid;
	logic          push_ready;
	crt_pkg::rsp_t push_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_interval_q <= crt_pkg::RETRY_INTERVAL_RESET;
			max_attempts_q   <= crt_pkg::MAX_ATTEMPTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crt_pkg::CFG_RETRY_INTERVAL: retry_interval_q <= cfg_data;
				crt_pkg::CFG_MAX_ATTEMPTS:   max_attempts_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	crt_engine #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.retry_interval(retry_interval_q),
		.max_attempts  (max_attempts_q),
		.push_valid    (push_valid),
		.push_rsp      (push_rsp),
		.push_ready    (push_ready)
	);

	crt_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_rsp  (push_rsp),
		.push_ready(push_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ hw/rtl/crt_out.sv @@
module crt_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  crt_pkg::rsp_t push_rsp,
	output logic          push_ready,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output crt_pkg::rsp_t rsp
);

	logic          out_valid_q;
	crt_pkg::rsp_t out_q;

	assign push_ready = !out_valid_q || !rsp_stall;
	assign rsp_valid  = out_valid_q;
	assign rsp        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			out_q <= push_rsp;
		end
	end

endmodule

@@ hw/rtl/crt_engine.sv @@
module crt_engine #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  crt_pkg::req_t req,
	input  logic [15:0]   retry_interval,
	input  logic [2:0]    max_attempts,
	output logic          push_valid,
	output crt_pkg::rsp_t push_rsp,
	input  logic          push_ready
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_ENTRIES - 1);

	crt_pkg::entry_t mem [TABLE_ENTRIES];
	crt_pkg::entry_t rdata_q;
	crt_pkg::entry_t wdata;
	logic [IW-1:0]   raddr;
	logic [IW-1:0]   waddr;
	logic            we;

	crt_pkg::state_t state_q, state_d;
	crt_pkg::req_t   item_q;
	logic [IW-1:0]   scan_q;
	logic            phase_q, phase_d;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic            found_m_q, found_f_q;
	logic [IW-1:0]   m_slot_q, f_slot_q;
	logic            pend_valid_q;
	crt_pkg::rsp_t   pend_q;

	logic            accept;
	logic            cur_valid;
	logic            hit;
	logic            room;
	logic [2:0]      ack_st;
	logic            ack_fin;
	logic [2:0]      tick_att;
	logic            have_free;
	logic [IW-1:0]   free_sel;
	logic            emit;
	crt_pkg::rsp_t   emit_rsp;
	logic            adv;
	logic            vclr;
	logic            vset;
	logic            rec_m;
	logic            rec_f;

	assign accept    = req_valid && (state_q == crt_pkg::S_IDLE);
	assign req_stall = (state_q != crt_pkg::S_IDLE);
	assign cur_valid = valid_q[scan_q];
	assign hit       = cur_valid && (rdata_q.vehicle == item_q.vehicle_id)
		&& (rdata_q.ctype == item_q.command_type);
	assign room      = !pend_valid_q || push_ready;
	assign ack_st    = (item_q.cmd == crt_pkg::CMD_CANCEL) ? crt_pkg::ST_CANCELED
		: item_q.ack_status;
	assign ack_fin   = (ack_st == crt_pkg::ST_COMPLETED) || (ack_st == crt_pkg::ST_REJECTED)
		|| (ack_st == crt_pkg::ST_CANCELED);
	assign tick_att  = rdata_q.attempts + 3'd1;
	assign have_free = found_m_q || found_f_q;
	assign free_sel  = (found_m_q && (!found_f_q || (m_slot_q < f_slot_q))) ? m_slot_q
		: f_slot_q;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		adv      = 1'b0;
		emit     = 1'b0;
		emit_rsp = '0;
		we       = 1'b0;
		waddr    = scan_q;
		wdata    = rdata_q;
		vclr     = 1'b0;
		vset     = 1'b0;
		rec_m    = 1'b0;
		rec_f    = 1'b0;
		raddr    = '0;
		case (state_q)
			crt_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = crt_pkg::S_SCAN;
				end
			end
			crt_pkg::S_SCAN: begin
				case (item_q.cmd)
					crt_pkg::CMD_ISSUE: begin
						if (hit && !found_m_q) begin
							if (room) begin
								emit                = 1'b1;
								emit_rsp.event_kind = crt_pkg::EV_STATUS;
								emit_rsp.entry_slot = 4'(scan_q);
								emit_rsp.out_vehicle = item_q.vehicle_id;
								emit_rsp.out_type   = item_q.command_type;
								emit_rsp.new_status = crt_pkg::ST_CANCELED;
								vclr                = 1'b1;
								rec_m               = 1'b1;
								adv                 = 1'b1;
							end
						end else begin
							rec_f = !cur_valid && !found_f_q;
							adv   = 1'b1;
						end
					end
					crt_pkg::CMD_ACK, crt_pkg::CMD_CANCEL: begin
						if (hit) begin
							if (room) begin
								emit                = 1'b1;
								emit_rsp.event_kind = crt_pkg::EV_STATUS;
								emit_rsp.entry_slot = 4'(scan_q);
								emit_rsp.out_vehicle = item_q.vehicle_id;
								emit_rsp.out_type   = item_q.command_type;
								emit_rsp.new_status = ack_st;
								vclr                = ack_fin;
								adv                 = 1'b1;
							end
						end else begin
							adv = 1'b1;
						end
					end
					crt_pkg::CMD_TICK: begin
						if (!cur_valid) begin
							adv = 1'b1;
						end else if (rdata_q.countdown > 16'd1) begin
							we              = 1'b1;
							wdata.countdown = rdata_q.countdown - 16'd1;
							adv             = 1'b1;
						end else if (!phase_q) begin
							if (room) begin
								emit                = 1'b1;
								emit_rsp.event_kind = crt_pkg::EV_SEND;
								emit_rsp.entry_slot = 4'(scan_q);
								emit_rsp.out_vehicle = rdata_q.vehicle;
								emit_rsp.out_type   = rdata_q.ctype;
								emit_rsp.attempt    = tick_att;
								if (tick_att >= max_attempts) begin
									phase_d = 1'b1;
								end else begin
									we              = 1'b1;
									wdata.attempts  = tick_att;
									wdata.countdown = retry_interval;
									adv             = 1'b1;
								end
							end
						end else begin
							if (room) begin
								emit                = 1'b1;
								emit_rsp.event_kind = crt_pkg::EV_STATUS;
								emit_rsp.entry_slot = 4'(scan_q);
								emit_rsp.out_vehicle = rdata_q.vehicle;
								emit_rsp.out_type   = rdata_q.ctype;
								emit_rsp.new_status = crt_pkg::ST_REJECTED;
								vclr                = 1'b1;
								phase_d             = 1'b0;
								adv                 = 1'b1;
							end
						end
					end
					default: begin
						adv = 1'b1;
					end
				endcase
				if (adv && (scan_q == LAST_SLOT)) begin
					state_d = (item_q.cmd == crt_pkg::CMD_ISSUE) ? crt_pkg::S_ALLOC
						: crt_pkg::S_FLUSH;
				end
				raddr = (adv && (scan_q != LAST_SLOT)) ? IW'(scan_q + 1'b1) : scan_q;
			end
			crt_pkg::S_ALLOC: begin
				if (room) begin
					emit                 = 1'b1;
					emit_rsp.out_vehicle = item_q.vehicle_id;
					emit_rsp.out_type    = item_q.command_type;
					if (have_free) begin
						emit_rsp.event_kind = crt_pkg::EV_SEND;
						emit_rsp.entry_slot = 4'(free_sel);
						we                  = 1'b1;
						waddr               = free_sel;
						wdata.vehicle       = item_q.vehicle_id;
						wdata.ctype         = item_q.command_type;
						wdata.attempts      = 3'd0;
						wdata.countdown     = retry_interval;
						vset                = 1'b1;
						state_d             = crt_pkg::S_REPORT;
					end else begin
						emit_rsp.event_kind = crt_pkg::EV_FULL;
						state_d             = crt_pkg::S_FLUSH;
					end
				end
			end
			crt_pkg::S_REPORT: begin
				if (room) begin
					emit                 = 1'b1;
					emit_rsp.event_kind  = crt_pkg::EV_STATUS;
					emit_rsp.entry_slot  = 4'(free_sel);
					emit_rsp.out_vehicle = item_q.vehicle_id;
					emit_rsp.out_type    = item_q.command_type;
					emit_rsp.new_status  = crt_pkg::ST_SENDING;
					state_d              = crt_pkg::S_FLUSH;
				end
			end
			crt_pkg::S_FLUSH: begin
				if (!pend_valid_q || push_ready) begin
					state_d = crt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = crt_pkg::S_IDLE;
			end
		endcase
	end

	assign push_valid = pend_valid_q && (emit || ((state_q == crt_pkg::S_FLUSH) && push_ready));

	always_comb begin
		push_rsp      = pend_q;
		push_rsp.last = (state_q == crt_pkg::S_FLUSH);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= crt_pkg::S_IDLE;
			phase_q      <= 1'b0;
			scan_q       <= '0;
			valid_q      <= '0;
			found_m_q    <= 1'b0;
			found_f_q    <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (accept) begin
				scan_q    <= '0;
				found_m_q <= 1'b0;
				found_f_q <= 1'b0;
			end else if (adv && (scan_q != LAST_SLOT)) begin
				scan_q <= IW'(scan_q + 1'b1);
			end
			if (rec_m) begin
				found_m_q <= 1'b1;
			end
			if (rec_f) begin
				found_f_q <= 1'b1;
			end
			if (vclr) begin
				valid_q[scan_q] <= 1'b0;
			end
			if (vset) begin
				valid_q[free_sel] <= 1'b1;
			end
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if ((state_q == crt_pkg::S_FLUSH) && push_ready) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (rec_m) begin
			m_slot_q <= scan_q;
		end
		if (rec_f) begin
			f_slot_q <= scan_q;
		end
		if (emit) begin
			pend_q <= emit_rsp;
		end
	end

`include "command_retry_tracker_top_assert.svh"

	`CRT_ASSERT_NOW(a_push_fits, clk, arst_n, push_valid, push_ready)
	`CRT_ASSERT_NOW(a_idle_drained, clk, arst_n, state_q == crt_pkg::S_IDLE, !pend_valid_q)
	`CRT_ASSERT_NOW(a_phase_tick, clk, arst_n, phase_q,
		(state_q == crt_pkg::S_SCAN) && (item_q.cmd == crt_pkg::CMD_TICK))
	`CRT_ASSERT_NOW(a_alloc_free, clk, arst_n,
		(state_q == crt_pkg::S_ALLOC) && have_free, !valid_q[free_sel])
	`CRT_ASSERT_NEXT(a_report_set, clk, arst_n, state_q == crt_pkg::S_REPORT,
		valid_q[free_sel])

endmodule

@@ bench/retry_tracker_checker.sv @@
`timescale 1ns / 100ps
module retry_tracker_checker
	import crt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	logic        slot_live  [TABLE_ENTRIES];
	logic [7:0]  slot_veh   [TABLE_ENTRIES];
	logic [7:0]  slot_kind  [TABLE_ENTRIES];
	logic [2:0]  slot_tries [TABLE_ENTRIES];
	logic [15:0] slot_timer [TABLE_ENTRIES];
	logic [15:0] interval_reg;
	logic [2:0]  attempts_limit;
	rsp_t        due_events [$];
	rsp_t        batch [2 * TABLE_ENTRIES + 2];
	int          batch_len;
	int          errors;
	rsp_t        want;
	int          i;

	function automatic logic holds(int slot, logic [7:0] veh, logic [7:0] typ);
		return slot_live[slot] && slot_veh[slot] == veh && slot_kind[slot] == typ;
	endfunction

	function automatic string show(rsp_t e);
		return $sformatf("kind %0d slot %0d vehicle %0d type %0d attempt %0d status %0d last %0d",
			e.event_kind, e.entry_slot, e.out_vehicle, e.out_type, e.attempt,
			e.new_status, e.last);
	endfunction

	task automatic note(evt_t kind, int slot, logic [7:0] veh, logic [7:0] typ,
			logic [2:0] att, logic [2:0] status);
		rsp_t e;
		e.event_kind = kind;
		e.entry_slot = slot[3:0];
		e.out_vehicle = veh;
		e.out_type = typ;
		e.attempt = att;
		e.new_status = status;
		e.last = 1'b0;
		batch[batch_len] = e;
		batch_len++;
	endtask

	task automatic track_request(req_t r);
		logic       done;
		logic [2:0] status;
		logic [2:0] tries;
		int         spare;
		int         s;
		batch_len = 0;
		case (r.cmd)
		CMD_ISSUE: begin
			done = 1'b0;
			for (s = 0; s < TABLE_ENTRIES; s++) begin
				if (!done && holds(s, r.vehicle_id, r.command_type)) begin
					slot_live[s] = 1'b0;
					note(EV_STATUS, s, r.vehicle_id, r.command_type, 3'd0, ST_CANCELED);
					done = 1'b1;
				end
			end
			spare = -1;
			for (s = TABLE_ENTRIES - 1; s >= 0; s--) begin
				if (!slot_live[s])
					spare = s;
			end
			if (spare < 0) begin
				note(EV_FULL, 0, r.vehicle_id, r.command_type, 3'd0, 3'd0);
			end else begin
				slot_live[spare] = 1'b1;
				slot_veh[spare] = r.vehicle_id;
				slot_kind[spare] = r.command_type;
				slot_tries[spare] = 3'd0;
				slot_timer[spare] = interval_reg;
				note(EV_SEND, spare, r.vehicle_id, r.command_type, 3'd0, 3'd0);
				note(EV_STATUS, spare, r.vehicle_id, r.command_type, 3'd0, ST_SENDING);
			end
		end
		CMD_ACK, CMD_CANCEL: begin
			status = (r.cmd == CMD_CANCEL) ? ST_CANCELED : r.ack_status;
			for (s = 0; s < TABLE_ENTRIES; s++) begin
				if (holds(s, r.vehicle_id, r.command_type)) begin
					if (status >= ST_COMPLETED && status <= ST_CANCELED)
						slot_live[s] = 1'b0;
					note(EV_STATUS, s, r.vehicle_id, r.command_type, 3'd0, status);
				end
			end
		end
		default: begin
			for (s = 0; s < TABLE_ENTRIES; s++) begin
				if (slot_live[s]) begin
					if (slot_timer[s] > 16'd1) begin
						slot_timer[s] = slot_timer[s] - 16'd1;
					end else begin
						tries = slot_tries[s] + 3'd1;
						slot_tries[s] = tries;
						note(EV_SEND, s, slot_veh[s], slot_kind[s], tries, 3'd0);
						if (tries >= attempts_limit) begin
							slot_live[s] = 1'b0;
							note(EV_STATUS, s, slot_veh[s], slot_kind[s], 3'd0, ST_REJECTED);
						end else begin
							slot_timer[s] = interval_reg;
						end
					end
				end
			end
		end
		endcase
		if (batch_len > 0)
			batch[batch_len - 1].last = 1'b1;
		for (s = 0; s < batch_len; s++)
			due_events.push_back(batch[s]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < TABLE_ENTRIES; i++)
				slot_live[i] = 1'b0;
			interval_reg = RETRY_INTERVAL_RESET;
			attempts_limit = MAX_ATTEMPTS_RESET;
			due_events.delete();
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_RETRY_INTERVAL: interval_reg = cfg_data;
				CFG_MAX_ATTEMPTS:   attempts_limit = cfg_data[2:0];
				default: ;
				endcase
			end
			if (req_valid && !req_stall)
				track_request(req);
			if (rsp_valid && !rsp_stall) begin
				if (due_events.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: unexpected event, got %s", show(rsp));
				end else begin
					want = due_events.pop_front();
					if (rsp.event_kind !== want.event_kind || rsp.entry_slot !== want.entry_slot
							|| rsp.out_vehicle !== want.out_vehicle
							|| rsp.out_type !== want.out_type || rsp.attempt !== want.attempt
							|| rsp.new_status !== want.new_status || rsp.last !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %s, got %s", show(want), show(rsp));
					end
				end
			end
			mismatches <= errors;
			outstanding <= due_events.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
	import crt_pkg::*;

	localparam int TABLE_ENTRIES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES + 10;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	req_t        req = '0;
	logic        rsp_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        req_stall;
	logic        rsp_valid;
	logic        cfg_ready;
	rsp_t        rsp;
	int          mismatches;
	int          outstanding;
	logic        gaps_on = 1'b0;
	logic        hold_wanted = 1'b0;
	int          cycle_count = 0;

	always #1 clk = ~clk;

	command_retry_tracker_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	retry_tracker_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) watch (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : receiver
		logic hold_done;
		int   stall_len;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !hold_done) begin
				hold_done = 1'b1;
				stall_len = HOLD_CYCLES;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall_len = $urandom_range(1, 14);
			end else begin
				stall_len = 0;
			end
			if (stall_len == 0) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b1;
				repeat (stall_len - 1) @(negedge clk);
			end
		end
	end

	function automatic req_t make_req(cmd_t c, logic [7:0] veh, logic [7:0] typ,
			logic [2:0] status);
		req_t r;
		r.cmd = c;
		r.vehicle_id = veh;
		r.command_type = typ;
		r.ack_status = status;
		return r;
	endfunction

	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 3));
	endfunction

	function automatic req_t random_request();
		int   roll;
		cmd_t c;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			c = CMD_ISSUE;
		else if (roll < 55)
			c = CMD_ACK;
		else if (roll < 65)
			c = CMD_CANCEL;
		else
			c = CMD_TICK;
		return make_req(c, pick_id(), pick_id(), 3'($urandom_range(0, 7)));
	endfunction

	task automatic offer(req_t item);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic [15:0] interval, logic [2:0] limit);
		drain();
		write_reg(CFG_RETRY_INTERVAL, interval);
		write_reg(CFG_MAX_ATTEMPTS, 16'(limit));
	endtask

	task automatic run_phase(logic [15:0] interval, logic [2:0] limit, logic gaps, int count);
		configure(interval, limit);
		gaps_on <= gaps;
		repeat (count) offer(random_request());
	endtask

	initial begin
		logic [7:0] fill_type [TABLE_ENTRIES];
		int         k;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gaps_on <= 1'b1;

		offer(make_req(CMD_ISSUE, 8'd0, 8'd0, 3'd0));
		offer(make_req(CMD_ISSUE, 8'd255, 8'd255, 3'd7));
		offer(make_req(CMD_ISSUE, 8'd0, 8'd0, 3'd0));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd0));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd1));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd2));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd6));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd7));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd3));
		offer(make_req(CMD_ACK, 8'd255, 8'd255, 3'd4));
		offer(make_req(CMD_CANCEL, 8'd0, 8'd0, 3'd7));
		offer(make_req(CMD_CANCEL, 8'd1, 8'd1, 3'd0));
		offer(make_req(CMD_TICK, 8'd0, 8'd0, 3'd0));
		offer(make_req(CMD_ISSUE, 8'h5a, 8'ha5, 3'd0));
		offer(make_req(CMD_ISSUE, 8'ha5, 8'h5a, 3'd0));
		offer(make_req(CMD_ACK, 8'ha5, 8'h5a, 3'd4));
		offer(make_req(CMD_ACK, 8'h5a, 8'ha5, 3'd5));

		// zero interval and zero attempt limit: fill, overflow, replace, then expire all
		configure(16'd0, 3'd0);
		for (k = 0; k < TABLE_ENTRIES; k++) begin
			fill_type[k] = 8'($urandom_range(0, 255));
			offer(make_req(CMD_ISSUE, 8'(k * 16 + 1), fill_type[k], 3'd0));
		end
		offer(make_req(CMD_ISSUE, 8'd200, 8'd200, 3'd0));
		offer(make_req(CMD_ISSUE, 8'd49, fill_type[3], 3'd0));
		offer(make_req(CMD_TICK, 8'd0, 8'd0, 3'd0));

		configure(16'd1, 3'd7);
		offer(make_req(CMD_ISSUE, 8'd7, 8'd7, 3'd0));
		offer(make_req(CMD_ISSUE, 8'd8, 8'd8, 3'd0));
		repeat (7) offer(make_req(CMD_TICK, 8'd0, 8'd0, 3'd0));

		configure(16'hffff, 3'd1);
		offer(make_req(CMD_ISSUE, 8'd9, 8'd9, 3'd0));
		offer(make_req(CMD_TICK, 8'd0, 8'd0, 3'd0));
		offer(make_req(CMD_CANCEL, 8'd9, 8'd9, 3'd0));

		run_phase(16'd1, 3'd1, 1'b1, 10);
		configure(16'd2, 3'd3);
		gaps_on <= 1'b1;
		hold_wanted <= 1'b1;
		repeat (10) offer(random_request());
		run_phase(16'd3, 3'd7, 1'($urandom_range(0, 1)), 10);
		run_phase(16'd1, 3'd5, 1'b1, 10);
		run_phase(16'd2, 3'd2, 1'b0, 10);

		drain();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/crt_pkg.sv
hw/rtl/crt_out.sv
hw/rtl/crt_engine.sv
hw/rtl/command_retry_tracker_top.sv
bench/retry_tracker_checker.sv
bench/testbench.sv
